// File: design/fcgi_pkg.sv
// Shared types and constants for the FastCGI record and params parser.
`timescale 1ns / 1ps
`default_nettype none

package fcgi_pkg;

	// Decoded pair length width; wider lengths saturate to LEN_MAX.
	localparam int PAIR_LEN_BITS = 31;
	localparam logic [30:0] LEN_MAX = 31'((64'd1 << PAIR_LEN_BITS) - 64'd1);

	// Parser phases
	localparam logic [2:0] PH_HEADER   = 3'd0;
	localparam logic [2:0] PH_NAMELEN  = 3'd1;
	localparam logic [2:0] PH_VALUELEN = 3'd2;
	localparam logic [2:0] PH_NAME     = 3'd3;
	localparam logic [2:0] PH_VALUE    = 3'd4;
	localparam logic [2:0] PH_OTHER    = 3'd5;
	localparam logic [2:0] PH_PAD      = 3'd6;
	localparam logic [2:0] PH_SKIP     = 3'd7;

	// Byte classes
	localparam logic [2:0] CLS_HEADER   = 3'd0;
	localparam logic [2:0] CLS_NAMELEN  = 3'd1;
	localparam logic [2:0] CLS_VALUELEN = 3'd2;
	localparam logic [2:0] CLS_NAME     = 3'd3;
	localparam logic [2:0] CLS_VALUE    = 3'd4;
	localparam logic [2:0] CLS_OTHER    = 3'd5;
	localparam logic [2:0] CLS_PAD      = 3'd6;
	localparam logic [2:0] CLS_OVERRUN  = 3'd7;

	localparam logic [7:0] TYPE_PARAMS = 8'd4;
	localparam logic [2:0] HEADER_LAST = 3'd7;

	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  data_byte;
		logic [7:0]  record_type;
		logic [15:0] request_id;
		logic [30:0] name_length;
		logic [30:0] value_length;
		logic        header_done;
		logic        pair_done;
		logic        record_done;
		logic        pair_overrun;
	} fcgi_result_t;

endpackage

`default_nettype wire

// File: design/fastcgi_record_params_parser_unit.sv
// Top level: FastCGI byte classifier with stream handshakes and output register.
//
// Usage:
//  - Slave channel s_*: one FastCGI stream byte per beat in s_tdata[7:0].
//  - Master channel m_*: one result beat per input byte, in stream order.
//    m_tdata carries the byte and the decoded record/pair context, m_tuser
//    the byte class and the header/pair/overrun flags, m_tlast marks the
//    last byte of a record (padding included).
//  - Latency: a result appears on m_* the cycle after its byte is taken.
//  - Throughput: one byte per cycle while the receiver keeps up; the parser state
//    updates in the same cycle the byte is accepted, so back-to-back bytes need no gaps.
//  - s_tready is high whenever the output register is empty or being
//    drained this cycle; a stalled receiver holds m_* stable and stops
//    input after one waiting beat.
//  - Reset (arst_n low) returns the parser to the start of a record header,
//    clears all counters and lengths and drops m_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module fastcgi_record_params_parser_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [95:0] m_tdata,   // [7:0] data_byte, [15:8] record_type, [31:16] request_id,
	                               // [62:32] name_length, [93:63] value_length, [95:94] zero
	output logic [5:0]  m_tuser,   // [2:0] byte_class, [3] header_done, [4] pair_done,
	                               // [5] pair_overrun
	output logic        m_tlast    // record_done
);
	import fcgi_pkg::*;

	logic         take;
	fcgi_result_t res;
	fcgi_result_t out_q;
	logic         out_valid_q;

	assign s_tready = !out_valid_q || m_tready;
	assign take     = s_tvalid && s_tready;

	fcgi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.in_byte(s_tdata),
		.result (res)
	);

	// output register: loads on every accepted beat, empties when drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (take)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_q.value_length, out_q.name_length, out_q.request_id,
		out_q.record_type, out_q.data_byte};
	assign m_tuser  = {out_q.pair_overrun, out_q.pair_done, out_q.header_done,
		out_q.byte_class};
	assign m_tlast  = out_q.record_done;

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> m_tvalid)
		else $error("accepted beat did not produce a result");

	a_hdr_class: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.header_done) |-> (out_q.byte_class == CLS_HEADER))
		else $error("header_done on a non-header byte");

	a_ovr_class: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.pair_overrun) |-> (out_q.byte_class == CLS_OVERRUN))
		else $error("pair_overrun without overrun class");

	a_pair_class: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.pair_done) |-> (out_q.byte_class == CLS_VALUELEN ||
		out_q.byte_class == CLS_NAME || out_q.byte_class == CLS_VALUE))
		else $error("pair_done on a byte outside a pair");

endmodule

`default_nettype wire

// File: design/fcgi_core.sv
// Parser state and per-byte next-state / classification logic.
`timescale 1ns / 1ps
`default_nettype none

module fcgi_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 take,
	input  wire  [7:0]          in_byte,
	output fcgi_pkg::fcgi_result_t result
);
	import fcgi_pkg::*;

	typedef struct packed {
		logic        done;
		logic [1:0]  idx;
		logic [30:0] acc;
	} len_step_t;

	function automatic logic [30:0] sat_len(input logic [30:0] x);
		return (x > LEN_MAX) ? LEN_MAX : x;
	endfunction

	// One byte of a pair length: short form, or four big-endian bytes, top bit masked.
	function automatic len_step_t take_len(input logic [1:0] idx, input logic [30:0] acc,
			input logic [7:0] b);
		len_step_t r;
		logic [30:0] shifted;
		shifted = {acc[22:0], b};
		r.done = 1'b0;
		r.idx  = idx;
		r.acc  = acc;
		if (idx == 2'd0) begin
			if (!b[7]) begin
				r.acc  = sat_len({23'd0, b});
				r.done = 1'b1;
			end else begin
				r.acc = {24'd0, b[6:0]};
				r.idx = 2'd1;
			end
		end else begin
			r.acc = shifted;
			if (idx == 2'd3) begin
				r.idx  = 2'd0;
				r.done = 1'b1;
				r.acc  = sat_len(shifted);
			end else begin
				r.idx = idx + 2'd1;
			end
		end
		return r;
	endfunction

	logic [2:0]  phase_q, n_phase;
	logic [2:0]  hidx_q, n_hidx;
	logic [7:0]  type_q, n_type;
	logic [15:0] req_q, n_req;
	logic [15:0] content_q, n_content;
	logic [7:0]  pad_q, n_pad;
	logic [1:0]  lbi_q, n_lbi;
	logic [30:0] name_q, n_name;
	logic [30:0] value_q, n_value;
	logic [30:0] field_q, n_field;

	logic [2:0]  cls;
	logic        hdone, pdone, rdone, ovr, content;
	logic [30:0] fl_dec;
	logic [31:0] need;
	len_step_t   lr;

	always_comb begin
		n_phase   = phase_q;
		n_hidx    = hidx_q;
		n_type    = type_q;
		n_req     = req_q;
		n_content = content_q;
		n_pad     = pad_q;
		n_lbi     = lbi_q;
		n_name    = name_q;
		n_value   = value_q;
		n_field   = field_q;
		cls       = CLS_HEADER;
		hdone     = 1'b0;
		pdone     = 1'b0;
		rdone     = 1'b0;
		ovr       = 1'b0;
		content   = 1'b0;
		lr        = '0;
		need      = '0;
		fl_dec    = (field_q != 31'd0) ? field_q - 31'd1 : field_q;
		if (phase_q != PH_HEADER && phase_q != PH_PAD && content_q != 16'd0)
			n_content = content_q - 16'd1;

		case (phase_q)
			PH_HEADER: begin
				cls = CLS_HEADER;
				case (hidx_q)
					3'd1: n_type = in_byte;
					3'd2: n_req[15:8] = in_byte;
					3'd3: n_req[7:0] = in_byte;
					3'd4: n_content[15:8] = in_byte;
					3'd5: n_content[7:0] = in_byte;
					3'd6: n_pad = in_byte;
					default: ;
				endcase
				if (hidx_q == HEADER_LAST) begin
					hdone   = 1'b1;
					n_hidx  = 3'd0;
					n_lbi   = 2'd0;
					n_name  = '0;
					n_value = '0;
					n_field = '0;
					if (n_content != 16'd0)
						n_phase = (n_type == TYPE_PARAMS) ? PH_NAMELEN : PH_OTHER;
					else if (n_pad != 8'd0)
						n_phase = PH_PAD;
					else begin
						n_phase = PH_HEADER;
						rdone   = 1'b1;
					end
				end else begin
					n_hidx = hidx_q + 3'd1;
				end
			end
			PH_NAMELEN: begin
				content = 1'b1;
				cls     = CLS_NAMELEN;
				if (lbi_q == 2'd0)
					n_value = '0;
				lr     = take_len(lbi_q, name_q, in_byte);
				n_name = lr.acc;
				n_lbi  = lr.idx;
				if (lr.done)
					n_phase = PH_VALUELEN;
				if (n_content == 16'd0) begin
					cls = CLS_OVERRUN;
					ovr = 1'b1;
				end
			end
			PH_VALUELEN: begin
				content = 1'b1;
				cls     = CLS_VALUELEN;
				lr      = take_len(lbi_q, value_q, in_byte);
				n_value = lr.acc;
				n_lbi   = lr.idx;
				need    = {1'b0, name_q} + {1'b0, lr.acc};
				if (lr.done) begin
					if (need > {16'd0, n_content}) begin
						cls     = CLS_OVERRUN;
						ovr     = 1'b1;
						n_phase = PH_SKIP;
					end else if (need == 32'd0) begin
						pdone   = 1'b1;
						n_phase = PH_NAMELEN;
					end else if (name_q != 31'd0) begin
						n_field = name_q;
						n_phase = PH_NAME;
					end else begin
						n_field = lr.acc;
						n_phase = PH_VALUE;
					end
				end else if (n_content == 16'd0) begin
					cls = CLS_OVERRUN;
					ovr = 1'b1;
				end
			end
			PH_NAME: begin
				content = 1'b1;
				cls     = CLS_NAME;
				n_field = fl_dec;
				if (fl_dec == 31'd0) begin
					if (value_q == 31'd0) begin
						pdone   = 1'b1;
						n_phase = PH_NAMELEN;
					end else begin
						n_field = value_q;
						n_phase = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				content = 1'b1;
				cls     = CLS_VALUE;
				n_field = fl_dec;
				if (fl_dec == 31'd0) begin
					pdone   = 1'b1;
					n_phase = PH_NAMELEN;
				end
			end
			PH_OTHER: begin
				content = 1'b1;
				cls     = CLS_OTHER;
			end
			PH_PAD: begin
				cls = CLS_PAD;
				if (pad_q != 8'd0)
					n_pad = pad_q - 8'd1;
				if (n_pad == 8'd0) begin
					rdone   = 1'b1;
					n_phase = PH_HEADER;
				end
			end
			default: begin
				content = 1'b1;
				cls     = CLS_OVERRUN;
			end
		endcase

		// content exhausted: go to padding or straight to the next header
		if (content && n_content == 16'd0) begin
			n_lbi = 2'd0;
			if (pad_q != 8'd0)
				n_phase = PH_PAD;
			else begin
				n_phase = PH_HEADER;
				rdone   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HEADER;
			hidx_q    <= '0;
			type_q    <= '0;
			req_q     <= '0;
			content_q <= '0;
			pad_q     <= '0;
			lbi_q     <= '0;
			name_q    <= '0;
			value_q   <= '0;
			field_q   <= '0;
		end else if (take) begin
			phase_q   <= n_phase;
			hidx_q    <= n_hidx;
			type_q    <= n_type;
			req_q     <= n_req;
			content_q <= n_content;
			pad_q     <= n_pad;
			lbi_q     <= n_lbi;
			name_q    <= n_name;
			value_q   <= n_value;
			field_q   <= n_field;
		end
	end

	assign result.byte_class   = cls;
	assign result.data_byte    = in_byte;
	assign result.record_type  = n_type;
	assign result.request_id   = n_req;
	assign result.name_length  = n_name;
	assign result.value_length = n_value;
	assign result.header_done  = hdone;
	assign result.pair_done    = pdone;
	assign result.record_done  = rdone;
	assign result.pair_overrun = ovr;

endmodule

`default_nettype wire

// File: tb/fastcgi_record_params_parser_unit_tb.sv
// Self-checking testbench for the FastCGI record and params byte classifier.
`timescale 1ns / 1ps

module fastcgi_record_params_parser_unit_tb;
	import fcgi_pkg::*;

	// Header byte positions. The version byte and the reserved byte are not decoded.
	localparam logic [2:0] HDR_TYPE    = 3'd1;
	localparam logic [2:0] HDR_REQ_HI  = 3'd2;
	localparam logic [2:0] HDR_REQ_LO  = 3'd3;
	localparam logic [2:0] HDR_CLEN_HI = 3'd4;
	localparam logic [2:0] HDR_CLEN_LO = 3'd5;
	localparam logic [2:0] HDR_PAD     = 3'd6;

	localparam int RANDOM_BYTES = 1950;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [5:0]  m_tuser;
	logic        m_tlast;

	fastcgi_record_params_parser_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// Stream bytes waiting to be sent, the record body under construction, and
	// the parse results predicted for bytes already taken by the block.
	logic [7:0]   stream_q[$];
	logic [7:0]   body_q[$];
	fcgi_result_t parsed_q[$];
	int           bytes_made = 0;
	int           mismatches = 0;

	// ------------------------------------------------------------------
	// Parser prediction: the testbench's own copy of the parse state.
	// ------------------------------------------------------------------
	logic [2:0]  phase = PH_HEADER;
	logic [2:0]  hdr_idx = 3'd0;
	logic [7:0]  cur_type = 8'd0;
	logic [15:0] cur_req = 16'd0;
	logic [15:0] content_left = 16'd0;
	logic [7:0]  pad_left = 8'd0;
	logic [1:0]  len_idx = 2'd0;
	logic [30:0] name_acc = 31'd0;
	logic [30:0] value_acc = 31'd0;
	logic [30:0] field_left = 31'd0;

	// One pair length byte. A clear top bit ends a one-byte length; a set top bit
	// starts a four-byte big-endian length with that bit dropped. At the full
	// 31-bit width the accumulator can never pass LEN_MAX, so nothing saturates.
	function automatic logic take_len(input logic [7:0] b, input logic to_value);
		logic [30:0] acc;
		logic        done;
		acc = to_value ? value_acc : name_acc;
		done = 1'b0;
		if (len_idx == 2'd0) begin
			if (!b[7]) begin
				acc = {23'd0, b};
				done = 1'b1;
			end else begin
				acc = {24'd0, b[6:0]};
				len_idx = 2'd1;
			end
		end else begin
			acc = {acc[22:0], b};
			if (len_idx == 2'd3) begin
				len_idx = 2'd0;
				done = 1'b1;
			end else begin
				len_idx = len_idx + 2'd1;
			end
		end
		if (to_value)
			value_acc = acc;
		else
			name_acc = acc;
		return done;
	endfunction

	// Content exhausted: go to padding, or close the record right away.
	function automatic logic close_content();
		if (pad_left != 8'd0) begin
			phase = PH_PAD;
			return 1'b0;
		end
		phase = PH_HEADER;
		return 1'b1;
	endfunction

	task automatic parse_fcgi_byte(input logic [7:0] b);
		fcgi_result_t r;
		logic         in_content;
		logic [31:0]  need;
		r = '0;
		r.data_byte = b;
		in_content = 1'b0;
		case (phase)
			PH_HEADER: begin
				r.byte_class = CLS_HEADER;
				case (hdr_idx)
					HDR_TYPE:    cur_type = b;
					HDR_REQ_HI:  cur_req[15:8] = b;
					HDR_REQ_LO:  cur_req[7:0] = b;
					HDR_CLEN_HI: content_left[15:8] = b;
					HDR_CLEN_LO: content_left[7:0] = b;
					HDR_PAD:     pad_left = b;
					default: ;
				endcase
				if (hdr_idx == HEADER_LAST) begin
					r.header_done = 1'b1;
					hdr_idx = 3'd0;
					len_idx = 2'd0;
					name_acc = 31'd0;
					value_acc = 31'd0;
					field_left = 31'd0;
					if (content_left != 16'd0)
						phase = (cur_type == TYPE_PARAMS) ? PH_NAMELEN : PH_OTHER;
					else
						r.record_done = close_content();
				end else begin
					hdr_idx = hdr_idx + 3'd1;
				end
			end
			PH_NAMELEN: begin
				in_content = 1'b1;
				r.byte_class = CLS_NAMELEN;
				if (len_idx == 2'd0) begin
					name_acc = 31'd0;
					value_acc = 31'd0;
				end
				if (content_left != 16'd0)
					content_left = content_left - 16'd1;
				if (take_len(b, 1'b0))
					phase = PH_VALUELEN;
				// content ran out with the pair still unfinished
				if (content_left == 16'd0) begin
					r.byte_class = CLS_OVERRUN;
					r.pair_overrun = 1'b1;
				end
			end
			PH_VALUELEN: begin
				in_content = 1'b1;
				r.byte_class = CLS_VALUELEN;
				if (content_left != 16'd0)
					content_left = content_left - 16'd1;
				if (take_len(b, 1'b1)) begin
					need = {1'b0, name_acc} + {1'b0, value_acc};
					if (need > {16'd0, content_left}) begin
						// pair too long: skip the rest of the content
						r.byte_class = CLS_OVERRUN;
						r.pair_overrun = 1'b1;
						phase = PH_SKIP;
					end else if (need == 32'd0) begin
						r.pair_done = 1'b1;
						phase = PH_NAMELEN;
					end else if (name_acc != 31'd0) begin
						field_left = name_acc;
						phase = PH_NAME;
					end else begin
						field_left = value_acc;
						phase = PH_VALUE;
					end
				end else if (content_left == 16'd0) begin
					r.byte_class = CLS_OVERRUN;
					r.pair_overrun = 1'b1;
				end
			end
			PH_NAME: begin
				in_content = 1'b1;
				r.byte_class = CLS_NAME;
				if (content_left != 16'd0)
					content_left = content_left - 16'd1;
				if (field_left != 31'd0)
					field_left = field_left - 31'd1;
				if (field_left == 31'd0) begin
					if (value_acc == 31'd0) begin
						r.pair_done = 1'b1;
						phase = PH_NAMELEN;
					end else begin
						field_left = value_acc;
						phase = PH_VALUE;
					end
				end
			end
			PH_VALUE: begin
				in_content = 1'b1;
				r.byte_class = CLS_VALUE;
				if (content_left != 16'd0)
					content_left = content_left - 16'd1;
				if (field_left != 31'd0)
					field_left = field_left - 31'd1;
				if (field_left == 31'd0) begin
					r.pair_done = 1'b1;
					phase = PH_NAMELEN;
				end
			end
			PH_OTHER: begin
				in_content = 1'b1;
				r.byte_class = CLS_OTHER;
				if (content_left != 16'd0)
					content_left = content_left - 16'd1;
			end
			PH_PAD: begin
				r.byte_class = CLS_PAD;
				if (pad_left != 8'd0)
					pad_left = pad_left - 8'd1;
				if (pad_left == 8'd0) begin
					r.record_done = 1'b1;
					phase = PH_HEADER;
				end
			end
			default: begin
				in_content = 1'b1;
				r.byte_class = CLS_OVERRUN;
				if (content_left != 16'd0)
					content_left = content_left - 16'd1;
			end
		endcase
		if (in_content && content_left == 16'd0) begin
			len_idx = 2'd0;
			r.record_done = close_content();
		end
		r.record_type = cur_type;
		r.request_id = cur_req;
		r.name_length = name_acc;
		r.value_length = value_acc;
		parsed_q.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Record builders: the body is assembled in body_q, then a header with
	// the matching content length is placed in front of it.
	// ------------------------------------------------------------------
	task automatic push_fill(input int unsigned n);
		repeat (n) body_q.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic push_len(input logic [30:0] len, input bit wide);
		if (!wide && len < 31'd128) begin
			body_q.push_back(len[7:0]);
		end else begin
			body_q.push_back({1'b1, len[30:24]});
			body_q.push_back(len[23:16]);
			body_q.push_back(len[15:8]);
			body_q.push_back(len[7:0]);
		end
	endtask

	// Mostly short lengths, some zero, now and then one that needs four bytes.
	function automatic int unsigned pick_len();
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 3)
			return 0;
		if (r == 19)
			return $urandom_range(128, 170);
		return $urandom_range(1, 9);
	endfunction

	task automatic push_pair(input int unsigned nl, input int unsigned vl);
		push_len(31'(nl), $urandom_range(0, 3) == 0);
		push_len(31'(vl), $urandom_range(0, 3) == 0);
		push_fill(nl + vl);
	endtask

	task automatic push_record(input logic [7:0] rtype, input logic [15:0] rid,
			input logic [7:0] pad);
		logic [15:0] clen;
		clen = 16'(body_q.size());
		stream_q.push_back(8'($urandom_range(0, 255)));   // version
		stream_q.push_back(rtype);
		stream_q.push_back(rid[15:8]);
		stream_q.push_back(rid[7:0]);
		stream_q.push_back(clen[15:8]);
		stream_q.push_back(clen[7:0]);
		stream_q.push_back(pad);
		stream_q.push_back(8'($urandom_range(0, 255)));   // reserved
		foreach (body_q[i]) stream_q.push_back(body_q[i]);
		repeat (pad) stream_q.push_back(8'($urandom_range(0, 255)));
		bytes_made += 8 + clen + pad;
		body_q.delete();
	endtask

	function automatic logic [7:0] pick_pad();
		int unsigned r;
		r = $urandom_range(0, 49);
		if (r == 0)
			return 8'hFF;
		if (r < 25)
			return 8'd0;
		return 8'($urandom_range(1, 7));
	endfunction

	function automatic logic [7:0] pick_other_type();
		logic [7:0] t;
		do
			t = 8'($urandom_range(0, 255));
		while (t == TYPE_PARAMS);
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Sender: pops stream_q in bursts of random length separated by random
	// gaps. A beat is taken at the edge where s_tvalid and s_tready are both
	// high; the byte is fed to the predictor at that same edge.
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin : stream_driver
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= 8'd0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				parse_fcgi_byte(s_tdata);
			if (!s_tvalid || s_tready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (stream_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= stream_q.pop_front();
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 48);
						// a third of the bursts follow with no gap at all
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: m_tready follows one of three randomly chosen modes:
	// always ready, mostly ready, mostly stalled.
	// ------------------------------------------------------------------
	int ready_mode = 0;
	int mode_left = 0;

	always @(posedge clk or negedge arst_n) begin : result_sink
		if (!arst_n) begin
			m_tready <= 1'b0;
			ready_mode <= 0;
			mode_left <= 0;
		end else begin
			if (mode_left == 0) begin
				ready_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(16, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (ready_mode)
				0:       m_tready <= 1'b1;
				1:       m_tready <= ($urandom_range(0, 3) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Result check: each result beat against the oldest predicted parse.
	// ------------------------------------------------------------------
	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : result_monitor
		fcgi_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (parsed_q.size() == 0) begin
				$error("result beat with no byte outstanding: m_tdata=0x%0h", m_tdata);
				mismatches++;
			end else begin
				want = parsed_q.pop_front();
				check_field("byte_class", 32'(want.byte_class), 32'(m_tuser[2:0]));
				check_field("data_byte", 32'(want.data_byte), 32'(m_tdata[7:0]));
				check_field("record_type", 32'(want.record_type), 32'(m_tdata[15:8]));
				check_field("request_id", 32'(want.request_id), 32'(m_tdata[31:16]));
				check_field("name_length", 32'(want.name_length), 32'(m_tdata[62:32]));
				check_field("value_length", 32'(want.value_length), 32'(m_tdata[93:63]));
				check_field("header_done", 32'(want.header_done), 32'(m_tuser[3]));
				check_field("pair_done", 32'(want.pair_done), 32'(m_tuser[4]));
				check_field("record_done", 32'(want.record_done), 32'(m_tlast));
				check_field("pair_overrun", 32'(want.pair_overrun), 32'(m_tuser[5]));
			end
		end
	end

	// Sender idle and every predicted result delivered.
	task automatic wait_drained();
		while (stream_q.size() != 0 || s_tvalid || parsed_q.size() != 0)
			@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		int          target;
		bit          paused;
		int unsigned kind;
		int unsigned filler;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty params record: record ends on the last header byte.
		push_record(TYPE_PARAMS, 16'hFFFF, 8'd0);
		// Zero-length pair followed by one padding byte.
		push_len(31'd0, 1'b0);
		push_len(31'd0, 1'b0);
		push_record(TYPE_PARAMS, 16'h0000, 8'd1);
		// Content ends inside a four-byte name length.
		body_q.push_back(8'h80);
		push_record(TYPE_PARAMS, 16'h1234, 8'd0);
		// No content, padding straight after the header.
		push_record(8'd1, 16'h00FF, 8'd1);
		wait_drained();

		target = bytes_made + RANDOM_BYTES;
		paused = 1'b0;
		while (bytes_made < target) begin
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				// well-formed params record
				repeat ($urandom_range(0, 4)) push_pair(pick_len(), pick_len());
				push_record(TYPE_PARAMS, 16'($urandom_range(0, 65535)), pick_pad());
			end else if (kind < 70) begin
				// good pairs, then a broken one
				repeat ($urandom_range(0, 2)) push_pair(pick_len(), pick_len());
				case ($urandom_range(0, 2))
					0: begin
						// name + value just past what is left
						filler = $urandom_range(0, 5);
						push_len(31'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
						push_len(31'(filler + $urandom_range(1, 4)),
							1'($urandom_range(0, 1)));
						push_fill(filler);
					end
					1: begin
						// huge four-byte value length
						push_len(31'($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
						push_len(31'($urandom) | 31'h0100_0000, 1'b1);
						push_fill($urandom_range(0, 6));
					end
					default: begin
						// content stops partway through a four-byte length
						if ($urandom_range(0, 1))
							push_len(31'(pick_len()), 1'($urandom_range(0, 1)));
						body_q.push_back(8'h80 | 8'($urandom_range(0, 127)));
						push_fill($urandom_range(0, 2));
					end
				endcase
				push_record(TYPE_PARAMS, 16'($urandom_range(0, 65535)), pick_pad());
			end else if (kind < 90) begin
				// non-params record, occasionally a long one
				push_fill(($urandom_range(0, 29) == 0) ? $urandom_range(200, 260)
					: $urandom_range(0, 12));
				push_record(pick_other_type(), 16'($urandom_range(0, 65535)), pick_pad());
			end else begin
				// random bytes as params content
				push_fill($urandom_range(1, 16));
				push_record(TYPE_PARAMS, 16'($urandom_range(0, 65535)), pick_pad());
			end
			// halfway, hold the sender until the block has delivered everything
			if (!paused && bytes_made >= target - RANDOM_BYTES / 2) begin
				paused = 1'b1;
				wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("fastcgi_record_params_parser_unit verification clean");
		else
			$display("fastcgi_record_params_parser_unit verification failed");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin : watchdog
		#10_000_000;
		$display("fastcgi_record_params_parser_unit verification failed");
		$finish;
	end

endmodule
